>>> rtl/dpfrc_pkg.sv
`timescale 1ns / 1ps

package dpfrc_pkg;

    // Table geometry
    localparam int MAX_N       = 65535;
    localparam int CLASS_COUNT = 11;
    localparam int IDX_W       = 16;   // addresses 0..MAX_N
    localparam int CNT_W       = 16;   // prefix counts
    localparam int CLS_W       = 4;    // class field / factor count width

    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [CNT_W-1:0]                   t_cnt;
    typedef logic [CLS_W-1:0]                   t_cls;
    typedef logic [CLASS_COUNT-1:0][CNT_W-1:0]  t_row;

    localparam t_idx LAST_IDX = IDX_W'(MAX_N);

    // Microprogram addresses
    typedef logic [3:0] t_upc;

    localparam t_upc U_BOOT  = 4'd0;   // waiting for first query, tables not built
    localparam t_upc U_CLR   = 4'd1;   // clear factor counts
    localparam t_upc U_PINIT = 4'd2;
    localparam t_upc U_PRD   = 4'd3;   // read count of candidate prime
    localparam t_upc U_PTST  = 4'd4;
    localparam t_upc U_MRD   = 4'd5;   // read count of a multiple
    localparam t_upc U_MWR   = 4'd6;   // write it back plus one
    localparam t_upc U_PNXT  = 4'd7;
    localparam t_upc U_SINIT = 4'd8;   // prefix row zero
    localparam t_upc U_SRD   = 4'd9;
    localparam t_upc U_SWR   = 4'd10;  // accumulate and write prefix row
    localparam t_upc U_QH    = 4'd11;  // read prefix at range high
    localparam t_upc U_QL    = 4'd12;  // read prefix at range low - 1
    localparam t_upc U_QOUT  = 4'd13;  // difference into output register
    localparam t_upc U_IDLE  = 4'd14;  // waiting for query, tables built

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,     // ready, clear index on accept
        OP_TAKE_Q,   // ready, start prefix read from port on accept
        OP_CLR,
        OP_PINIT,
        OP_RD_P,
        OP_RD_M,
        OP_INC_M,
        OP_PINC,
        OP_SINIT,
        OP_RD_J,
        OP_ACC,
        OP_RD_HI,
        OP_RD_LO,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_FC_NZ,
        C_IDX_MAX,
        C_M_LAST,
        C_P_MAX,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  jt;   // next step when cond holds
        t_upc  jf;   // next step otherwise
    } t_uword;

    function automatic t_uword uword(input t_upc upc);
        t_uword w;
        case (upc)
            U_BOOT:  w = '{OP_TAKE,   C_ACCEPT,   U_CLR,   U_BOOT};
            U_CLR:   w = '{OP_CLR,    C_IDX_MAX,  U_PINIT, U_CLR};
            U_PINIT: w = '{OP_PINIT,  C_ALWAYS,   U_PRD,   U_PRD};
            U_PRD:   w = '{OP_RD_P,   C_ALWAYS,   U_PTST,  U_PTST};
            U_PTST:  w = '{OP_NONE,   C_FC_NZ,    U_PNXT,  U_MRD};
            U_MRD:   w = '{OP_RD_M,   C_ALWAYS,   U_MWR,   U_MWR};
            U_MWR:   w = '{OP_INC_M,  C_M_LAST,   U_PNXT,  U_MRD};
            U_PNXT:  w = '{OP_PINC,   C_P_MAX,    U_SINIT, U_PRD};
            U_SINIT: w = '{OP_SINIT,  C_ALWAYS,   U_SRD,   U_SRD};
            U_SRD:   w = '{OP_RD_J,   C_ALWAYS,   U_SWR,   U_SWR};
            U_SWR:   w = '{OP_ACC,    C_IDX_MAX,  U_QH,    U_SRD};
            U_QH:    w = '{OP_RD_HI,  C_ALWAYS,   U_QL,    U_QL};
            U_QL:    w = '{OP_RD_LO,  C_ALWAYS,   U_QOUT,  U_QOUT};
            U_QOUT:  w = '{OP_OUT,    C_OUT_FREE, U_IDLE,  U_QOUT};
            U_IDLE:  w = '{OP_TAKE_Q, C_ACCEPT,   U_QL,    U_IDLE};
            default: w = '{OP_NONE,   C_ALWAYS,   U_BOOT,  U_BOOT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/distinct_prime_factor_range_count.sv
// Counts the integers in [range_low, range_high] that have exactly factor_class distinct
// prime factors (1 has none). The first query after reset triggers a one-time table build:
// a clearing pass over the 64K-entry factor count memory, a sieve that does a
// read/increment/write for every multiple of every prime, and a scan that writes one
// 11-class prefix row per integer. After that each accepted beat is answered from the
// prefix memory, and a new beat is taken only once the previous result is in the output
// register: the prefix memory has one read port, so the high and low-minus-one rows are
// read one after the other, then subtracted. Ranges with low of zero, low above high or
// high past MAX_N return count 0 with bad_query set; a class of 11 or more returns count 0
// with bad_query clear. One query is in flight at a time; the result sits in an output
// register until taken.
`timescale 1ns / 1ps

module distinct_prime_factor_range_count (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  dpfrc_pkg::t_idx       i_range_low,
    input  dpfrc_pkg::t_idx       i_range_high,
    input  dpfrc_pkg::t_cls       i_factor_class,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output dpfrc_pkg::t_cnt       o_match_count,
    output logic                  o_bad_query
);
    import dpfrc_pkg::*;

    // Memories: per-integer distinct prime count, and per-integer prefix row of all classes
    t_cls fc_mem [0:MAX_N];
    t_row pf_mem [0:MAX_N];

    // Sequencer
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   cond_hit;

    // Datapath registers
    t_idx r_idx, n_idx;     // multiple m / scan index j
    t_idx r_p, n_p;         // candidate prime
    t_row r_runs, n_runs;   // running class counts
    t_cls r_fc_rd;          // registered factor count read
    t_row r_pf_rd;          // registered prefix row read
    t_idx r_lo, r_hi;
    t_cls r_cls;
    t_cnt r_hicnt, n_hicnt;

    logic r_out_valid, n_out_valid;
    t_cnt r_count, n_count;
    logic r_bad, n_bad;

    // Memory controls
    logic fc_we, fc_re;
    t_idx fc_addr;
    t_cls fc_wdata;
    logic pf_we, pf_re;
    t_idx pf_addr;

    logic            accept;
    logic            out_free;
    logic [IDX_W:0]  m_next;
    logic            q_bad, q_cls_ok;
    t_cls            scan_cls;
    t_cnt            lo_cnt;

    assign uw       = uword(r_upc);
    assign o_in_ready = (uw.op == OP_TAKE) || (uw.op == OP_TAKE_Q);
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign m_next   = {1'b0, r_idx} + {1'b0, r_p};

    // Query checks on the latched beat
    assign q_bad    = (r_lo == '0) || (r_lo > r_hi) || (r_hi > LAST_IDX);
    assign q_cls_ok = r_cls < CLS_W'(CLASS_COUNT);
    assign lo_cnt   = q_cls_ok ? r_pf_rd[r_cls] : '0;

    // 1 has no prime factors even though the sieve never touches it
    assign scan_cls = (r_idx == IDX_W'(1)) ? '0 : r_fc_rd;

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_ACCEPT:   cond_hit = accept;
            C_FC_NZ:    cond_hit = (r_fc_rd != '0);
            C_IDX_MAX:  cond_hit = (r_idx == LAST_IDX);
            C_M_LAST:   cond_hit = (m_next > {1'b0, LAST_IDX});
            C_P_MAX:    cond_hit = (r_p == LAST_IDX);
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b1;
        endcase
        n_upc = cond_hit ? uw.jt : uw.jf;
    end

    // Control word decode into the datapath
    always_comb begin
        fc_we    = 1'b0;
        fc_re    = 1'b0;
        fc_addr  = r_idx;
        fc_wdata = '0;
        pf_we    = 1'b0;
        pf_re    = 1'b0;
        pf_addr  = r_idx;
        n_idx    = r_idx;
        n_p      = r_p;
        n_runs   = r_runs;
        n_hicnt  = r_hicnt;
        n_count  = r_count;
        n_bad    = r_bad;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;

        case (uw.op)
            OP_TAKE: begin
                if (accept) begin
                    n_idx = '0;
                end
            end
            OP_TAKE_Q: begin
                if (accept) begin
                    pf_re   = 1'b1;
                    pf_addr = i_range_high;
                end
            end
            OP_CLR: begin
                fc_we = 1'b1;
                n_idx = r_idx + IDX_W'(1);
            end
            OP_PINIT: begin
                n_p = IDX_W'(2);
            end
            OP_RD_P: begin
                fc_re   = 1'b1;
                fc_addr = r_p;
                n_idx   = r_p;
            end
            OP_RD_M: begin
                fc_re = 1'b1;
            end
            OP_INC_M: begin
                fc_we    = 1'b1;
                fc_wdata = r_fc_rd + CLS_W'(1);
                n_idx    = m_next[IDX_W-1:0];
            end
            OP_PINC: begin
                n_p = r_p + IDX_W'(1);
            end
            OP_SINIT: begin
                n_runs  = '0;
                pf_we   = 1'b1;
                pf_addr = '0;
                n_idx   = IDX_W'(1);
            end
            OP_RD_J: begin
                fc_re = 1'b1;
            end
            OP_ACC: begin
                for (int k = 0; k < CLASS_COUNT; k++) begin
                    if (scan_cls == CLS_W'(k)) begin
                        n_runs[k] = r_runs[k] + CNT_W'(1);
                    end
                end
                pf_we = 1'b1;
                n_idx = r_idx + IDX_W'(1);
            end
            OP_RD_HI: begin
                pf_re   = 1'b1;
                pf_addr = r_hi;
            end
            OP_RD_LO: begin
                // row at range high lands now; fetch row at range low - 1
                n_hicnt = q_cls_ok ? r_pf_rd[r_cls] : '0;
                pf_re   = 1'b1;
                pf_addr = r_lo - IDX_W'(1);
            end
            OP_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_bad       = q_bad;
                    n_count     = (q_bad || !q_cls_ok) ? '0 : (r_hicnt - lo_cnt);
                end
            end
            default: begin
            end
        endcase
    end

    // Factor count memory
    always_ff @(posedge i_clk) begin
        if (fc_we) begin
            fc_mem[fc_addr] <= fc_wdata;
        end
        if (fc_re) begin
            r_fc_rd <= fc_mem[fc_addr];
        end
    end

    // Prefix row memory
    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            pf_mem[pf_addr] <= n_runs;
        end
        if (pf_re) begin
            r_pf_rd <= pf_mem[pf_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_p     <= n_p;
        r_runs  <= n_runs;
        r_hicnt <= n_hicnt;
        r_count <= n_count;
        r_bad   <= n_bad;
        if (accept) begin
            r_lo  <= i_range_low;
            r_hi  <= i_range_high;
            r_cls <= i_factor_class;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_count = r_count;
    assign o_bad_query   = r_bad;

endmodule
